// ===== rtl/sdct_pkg.sv =====
// ----------------------------------------------------------------------------
// sdct_pkg
// Shared types and constants for the sensor duty-cycle timer.
// ----------------------------------------------------------------------------
package sdct_pkg;

   // default tick length in ms
   localparam int TICK_MS_DEFAULT = 10;

   // period / capture limits, seconds
   localparam int SECS_W          = 6;
   localparam int MIN_S           = 5;
   localparam int MAX_S           = 60;
   localparam int MS_PER_S        = 1000;
   localparam int RESET_PERIOD_S  = 10;
   localparam int RESET_CAPTURE_S = 5;

   // result queue depth
   localparam int OUT_DEPTH = 4;

   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_MODE    = 3'd1,
      REQ_PERIOD  = 3'd2,
      REQ_CAPTURE = 3'd3,
      REQ_STATUS  = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_CONT   = 2'd0,
      MODE_DUTY   = 2'd1,
      MODE_STREAM = 2'd2
   } mode_type;

   // one result word
   typedef struct packed {
      logic        sample_now;
      logic        send_due;
      logic        reply_valid;
      logic [1:0]  mode_now;
      logic [15:0] period_ms_now;
   } rsp_word_type;

endpackage

// ===== rtl/sensor_duty_cycle_timer.sv =====
// ----------------------------------------------------------------------------
// sensor_duty_cycle_timer
// Sequences sensor sampling: continuous, periodic capture/idle, or stream mode.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request word (tick, set mode, set period, set capture,
//   status). A word is taken on a rising edge with req_valid high and
//   req_stall low. Every request yields exactly one rsp_* word, in order.
//   rsp_* words leave through a 4-entry queue; the receiver holds rsp_stall
//   high to keep the current word on the port.
//   The result word passes through the input register, then the queue,
//   before it can be taken.
//   Throughput: one word per cycle while req_stall is low; the update is
//   one pass through the window compare and the seconds clamps.
//   req_stall rises only when the queue plus the word in the input register
//   leave no room for another word, i.e. after the receiver has stalled.
//   Reset (synchronous): continuous mode, 10 s period, 5 s capture, phase
//   at the start of capture, queue empty.
//   TICK_MS sets the tick length; window lengths are ceil(ms / TICK_MS).
// ----------------------------------------------------------------------------
module sensor_duty_cycle_timer #(
   parameter int TICK_MS = sdct_pkg::TICK_MS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_type,
   input  logic [1:0]  req_args_present,
   input  logic [7:0]  req_mode_value,
   input  logic [15:0] req_seconds,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_sample_now,
   output logic        rsp_send_due,
   output logic        rsp_reply_valid,
   output logic [1:0]  rsp_mode_now,
   output logic [15:0] rsp_period_ms_now
);
   import sdct_pkg::*;

   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   logic              res_valid;
   rsp_word_type      res_word;
   rsp_word_type      head_word;
   logic              fifo_ne;
   logic [CNT_W-1:0]  fifo_cnt;
   logic              pop;

   // accepted word enters only if the queue can still absorb it
   assign req_stall = ((CNT_W+1)'(fifo_cnt) + (CNT_W+1)'(res_valid))
                      >= (CNT_W+1)'(OUT_DEPTH);

   sdct_core #(
      .TICK_MS (TICK_MS)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid && !req_stall),
      .in_type         (req_type),
      .in_args_present (req_args_present),
      .in_mode_value   (req_mode_value),
      .in_seconds      (req_seconds),
      .res_valid       (res_valid),
      .res_word        (res_word)
   );

   assign pop = fifo_ne && !rsp_stall;

   sdct_fifo #(
      .DEPTH (OUT_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res_word),
      .pop       (pop),
      .not_empty (fifo_ne),
      .head_word (head_word),
      .count     (fifo_cnt)
   );

   // result port
   assign rsp_valid         = fifo_ne;
   assign rsp_sample_now    = head_word.sample_now;
   assign rsp_send_due      = head_word.send_due;
   assign rsp_reply_valid   = head_word.reply_valid;
   assign rsp_mode_now      = head_word.mode_now;
   assign rsp_period_ms_now = head_word.period_ms_now;

endmodule

// ===== rtl/sdct_core.sv =====
// ----------------------------------------------------------------------------
// sdct_core
// Input register, mode/period/phase state and the per-word update logic.
// ----------------------------------------------------------------------------
module sdct_core #(
   parameter int TICK_MS = sdct_pkg::TICK_MS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [2:0]            in_type,
   input  logic [1:0]            in_args_present,
   input  logic [7:0]            in_mode_value,
   input  logic [15:0]           in_seconds,
   output logic                  res_valid,
   output sdct_pkg::rsp_word_type res_word
);
   import sdct_pkg::*;

   // window length width: enough for the longest period in ticks
   localparam int MAX_TICKS = (MAX_S * MS_PER_S + TICK_MS - 1) / TICK_MS;
   localparam int LEN_W     = $clog2(MAX_TICKS + 1);
   localparam int TBL_N     = 2 ** SECS_W;

   typedef logic [LEN_W-1:0] len_type;
   typedef logic [SECS_W-1:0] secs_type;

   // seconds -> ticks, ceil(s * 1000 / TICK_MS), elaboration constants
   len_type len_tbl [TBL_N];
   for (genvar i = 0; i < TBL_N; i++) begin : g_len_tbl
      assign len_tbl[i] = LEN_W'((i * MS_PER_S + TICK_MS - 1) / TICK_MS);
   end

   // input register
   logic         in_v_ff;
   logic [2:0]   type_ff;
   logic [1:0]   args_ff;
   logic [7:0]   modev_ff;
   logic [15:0]  secs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         type_ff  <= in_type;
         args_ff  <= in_args_present;
         modev_ff <= in_mode_value;
         secs_ff  <= in_seconds;
      end
   end

   // state
   mode_type  mode_ff, mode_in;
   secs_type  per_s_ff, per_s_in;
   secs_type  cap_s_ff, cap_s_in;
   logic      capturing_ff, capturing_in;
   len_type   phase_ff, phase_in;
   len_type   cap_len_ff;
   len_type   sleep_len_ff;

   logic      sample, send, reply;
   len_type   phase_inc;
   logic [15:0] secs_lo;

   assign phase_inc = phase_ff + len_type'(1);

   // next-state and result flags
   always_comb begin
      mode_in      = mode_ff;
      per_s_in     = per_s_ff;
      cap_s_in     = cap_s_ff;
      capturing_in = capturing_ff;
      phase_in     = phase_ff;
      sample       = 1'b0;
      send         = 1'b0;
      reply        = 1'b0;
      secs_lo      = (secs_ff < 16'(MIN_S)) ? 16'(MIN_S) : secs_ff;

      if (in_v_ff) begin
         unique case (type_ff)
            REQ_TICK: begin
               if (mode_ff == MODE_CONT) begin
                  sample = 1'b1;
               end else if (mode_ff == MODE_DUTY) begin
                  if (capturing_ff) begin
                     sample = 1'b1;
                     if (phase_inc >= cap_len_ff) begin
                        phase_in     = '0;
                        send         = 1'b1;
                        capturing_in = (sleep_len_ff == '0);
                     end else begin
                        phase_in = phase_inc;
                     end
                  end else if (sleep_len_ff == '0) begin
                     capturing_in = 1'b1;
                     phase_in     = '0;
                  end else if (phase_inc >= sleep_len_ff) begin
                     capturing_in = 1'b1;
                     phase_in     = '0;
                  end else begin
                     phase_in = phase_inc;
                  end
               end
            end
            REQ_MODE: begin
               if (args_ff != 2'd0 && modev_ff < 8'd3) begin
                  mode_in = mode_type'(modev_ff[1:0]);
                  if (modev_ff[1:0] == MODE_DUTY) begin
                     capturing_in = 1'b1;
                     phase_in     = '0;
                  end
               end
            end
            REQ_PERIOD: begin
               if (args_ff >= 2'd2) begin
                  per_s_in = (secs_lo > 16'(MAX_S)) ? SECS_W'(MAX_S)
                                                    : SECS_W'(secs_lo);
                  if (cap_s_ff > per_s_in) begin
                     cap_s_in = per_s_in;
                  end
               end
            end
            REQ_CAPTURE: begin
               if (args_ff >= 2'd2) begin
                  cap_s_in = (secs_lo > 16'(per_s_ff)) ? per_s_ff
                                                       : SECS_W'(secs_lo);
               end
            end
            REQ_STATUS: begin
               reply = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // state registers; window lengths follow the stored seconds
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_CONT;
         per_s_ff     <= SECS_W'(RESET_PERIOD_S);
         cap_s_ff     <= SECS_W'(RESET_CAPTURE_S);
         capturing_ff <= 1'b1;
         phase_ff     <= '0;
         cap_len_ff   <= len_tbl[RESET_CAPTURE_S];
         sleep_len_ff <= len_tbl[RESET_PERIOD_S] - len_tbl[RESET_CAPTURE_S];
      end else begin
         mode_ff      <= mode_in;
         per_s_ff     <= per_s_in;
         cap_s_ff     <= cap_s_in;
         capturing_ff <= capturing_in;
         phase_ff     <= phase_in;
         cap_len_ff   <= len_tbl[cap_s_in];
         sleep_len_ff <= len_tbl[per_s_in] - len_tbl[cap_s_in];
      end
   end

   // result word
   assign res_valid              = in_v_ff;
   assign res_word.sample_now    = sample;
   assign res_word.send_due      = send;
   assign res_word.reply_valid   = reply;
   assign res_word.mode_now      = mode_in;
   assign res_word.period_ms_now = 16'(per_s_in) * 16'(MS_PER_S);

endmodule

// ===== rtl/sdct_fifo.sv =====
// ----------------------------------------------------------------------------
// sdct_fifo
// Small result queue that decouples the core from receiver stalls.
// ----------------------------------------------------------------------------
module sdct_fifo #(
   parameter int DEPTH = sdct_pkg::OUT_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sdct_pkg::rsp_word_type push_word,
   input  logic                   pop,
   output logic                   not_empty,
   output sdct_pkg::rsp_word_type head_word,
   output logic [$clog2(DEPTH+1)-1:0] count
);
   import sdct_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_word_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;

   // wrap pointers at the queue depth
   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      begin
         r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
         return r;
      end
   endfunction

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

   assign not_empty = (cnt_ff != '0);
   assign head_word = entry_ff[rd_ptr_ff];
   assign count     = cnt_ff;

endmodule

// ===== rtl/sdct_checker.sv =====
// ----------------------------------------------------------------------------
// sdct_checker
// Port-level checks on the result channel of the duty-cycle timer.
// ----------------------------------------------------------------------------
module sdct_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_sample_now,
   input logic        rsp_send_due,
   input logic        rsp_reply_valid,
   input logic [1:0]  rsp_mode_now,
   input logic [15:0] rsp_period_ms_now
);

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_period_ms_now)
         && $stable(rsp_mode_now) && $stable(rsp_sample_now)
         && $stable(rsp_send_due) && $stable(rsp_reply_valid))
      else $error("result word changed while stalled");

   // a status reply never comes with a sample or send
   a_reply_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_valid |-> !rsp_sample_now && !rsp_send_due)
      else $error("status reply flagged with sample or send");

   // end of capture is itself a sampling tick
   a_send_samples: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_due |-> rsp_sample_now)
      else $error("send_due without sample_now");

   // period stays inside 5 s .. 60 s, mode inside its codes
   a_period_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_period_ms_now >= 16'd5000 && rsp_period_ms_now <= 16'd60000
         && rsp_mode_now != 2'd3)
      else $error("period or mode out of range");

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

endmodule

bind sensor_duty_cycle_timer sdct_checker u_sdct_checker (.*);
